// ===== sv/lts_pkg.sv =====
// Package for the level topological sort block: modes and sequencer states.
`default_nettype none
package lts_pkg;
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_SET,
        ST_SHIFT,
        ST_PUT,
        ST_COLS,
        ST_DEG,
        ST_SCAN,
        ST_EMIT,
        ST_CYC
    } state_t;
endpackage
`default_nettype wire

// ===== sv/level_topological_sort.sv =====
// Level topological sort: label table, adjacency matrix and a row-at-a-time sequencer.
// Load: label search, table shift, then column shift; each row is read, then written.
// Edge: label search, then the bit is set when both labels are found. Clear: done in the accepting cycle.
// Run: in-degree build, then per level a scan and one word per emitted node, held by
// output stalls; with no ready node left a cycle-error word ends the run. One word at a time.
// Reset clears control state and node count; memories hold rows below the count only.
`default_nettype none
module level_topological_sort #(
    parameter int MAX_NODES  = 64,
    parameter int LABEL_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] node_label,
    input  wire logic [15:0] edge_to,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      sorted_label,
    output logic             level_end,
    output logic             cycle_error,
    output logic             last
);
    import lts_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int LW = (LABEL_BITS < 16) ? LABEL_BITS : 16;
    localparam logic [MAX_NODES-1:0] ONE_VEC = {{(MAX_NODES-1){1'b0}}, 1'b1};

    state_t state_reg, state_next;

    logic [LW-1:0]        label_table [MAX_NODES];
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [LW-1:0]        lab_q_reg;
    logic [MAX_NODES-1:0] row_q_reg;
    logic [CW-1:0]        deg_reg [MAX_NODES];
    logic [CW-1:0]        count_reg;
    logic [MAX_NODES-1:0] emitted_reg, level_reg;
    logic [CW-1:0]        idx_reg;
    logic                 ph_reg;
    logic [LW-1:0]        a_reg, b_reg;
    logic [1:0]           mode_reg;
    logic [IW-1:0]        pos_reg, xi_reg, yi_reg;
    logic                 dup_reg, xf_reg, yf_reg;
    logic [15:0]          o_label_reg;
    logic                 o_valid_reg, o_lend_reg, o_cyc_reg, o_last_reg;

    logic                 lab_we, adj_we, o_load;
    logic [IW-1:0]        wr_addr, rd_addr;
    logic [LW-1:0]        lab_wdata;
    logic [MAX_NODES-1:0] adj_wdata;

    logic [IW-1:0] idx;
    assign idx = idx_reg[IW-1:0];

    logic idx_done;
    assign idx_done = (idx_reg >= count_reg);

    // table shift walks down from the count to just above the insert place
    logic shift_done;
    assign shift_done = (idx_reg <= CW'(pos_reg));

    logic out_free;
    assign out_free = !o_valid_reg || !out_stall;

    // rest of level above current node
    logic [MAX_NODES-1:0] rest;
    assign rest = (level_reg >> idx) >> 1;

    logic [MAX_NODES-1:0] all_mask, ready_vec;
    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            all_mask[k]  = (CW'(k) < count_reg);
            ready_vec[k] = all_mask[k] && !emitted_reg[k] && (deg_reg[k] == '0);
        end
    end

    logic [MAX_NODES-1:0] low_mask;
    assign low_mask = (ONE_VEC << pos_reg) - 1'b1;

    // last-word marking needs lookahead: a level emit is final when no node is left
    logic final_level;
    assign final_level = ((emitted_reg | level_reg) & all_mask) == all_mask;

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = o_valid_reg;
    assign sorted_label = o_label_reg;
    assign level_end    = o_lend_reg;
    assign cycle_error  = o_cyc_reg;
    assign last         = o_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (mode_t'(mode) == MODE_RUN) state_next = ST_DEG;
                    else if (mode_t'(mode) != MODE_CLEAR) state_next = ST_FIND;
                end
            ST_FIND:
                if (idx_done)
                begin
                    if (mode_t'(mode_reg) == MODE_EDGE)
                        state_next = (xf_reg && yf_reg) ? ST_SET : ST_IDLE;
                    else if (dup_reg || count_reg == CW'(MAX_NODES)) state_next = ST_IDLE;
                    else state_next = ST_SHIFT;
                end
            ST_SET:   if (ph_reg) state_next = ST_IDLE;
            ST_SHIFT: if (shift_done) state_next = ST_PUT;
            ST_PUT:   state_next = ST_COLS;
            ST_COLS:  if (idx_done) state_next = ST_IDLE;
            ST_DEG:   if (idx_done) state_next = ST_SCAN;
            ST_SCAN:
                if ((emitted_reg & all_mask) == all_mask) state_next = ST_IDLE;
                else if (ready_vec == '0) state_next = ST_CYC;
                else state_next = ST_EMIT;
            ST_EMIT:  if (idx_done) state_next = ST_SCAN;
            ST_CYC:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory ports and output load; read data is registered and arrives in the cycle after the address
    always_comb
    begin
        lab_we    = 1'b0;
        adj_we    = 1'b0;
        o_load    = 1'b0;
        wr_addr   = idx;
        rd_addr   = idx;
        lab_wdata = lab_q_reg;
        adj_wdata = row_q_reg;
        unique case (state_reg)
            ST_SET:
            begin
                adj_we    = ph_reg;
                adj_wdata = row_q_reg | (ONE_VEC << yi_reg);
            end
            ST_SHIFT:
            begin
                rd_addr = idx - 1'b1;
                lab_we  = ph_reg && !shift_done;
                adj_we  = ph_reg && !shift_done;
            end
            ST_PUT:
            begin
                wr_addr   = pos_reg;
                lab_we    = 1'b1;
                adj_we    = 1'b1;
                lab_wdata = a_reg;
                adj_wdata = '0;
            end
            ST_COLS:
            begin
                adj_we    = ph_reg && !idx_done;
                adj_wdata = (row_q_reg & low_mask) | ((row_q_reg & ~low_mask) << 1);
            end
            ST_EMIT: o_load = !idx_done && level_reg[idx] && ph_reg && out_free;
            ST_CYC:  o_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
            label_table[wr_addr] <= lab_wdata;
        if (adj_we)
            adj_mem[wr_addr] <= adj_wdata;
        lab_q_reg <= label_table[rd_addr];
        row_q_reg <= adj_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_load)
            o_valid_reg <= 1'b1;
        else if (!out_stall)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            ph_reg      <= 1'b0;
            mode_reg    <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            pos_reg     <= '0;
            xi_reg      <= '0;
            yi_reg      <= '0;
            dup_reg     <= 1'b0;
            xf_reg      <= 1'b0;
            yf_reg      <= 1'b0;
            emitted_reg <= '0;
            level_reg   <= '0;
            o_label_reg <= '0;
            o_lend_reg  <= 1'b0;
            o_cyc_reg   <= 1'b0;
            o_last_reg  <= 1'b0;
            for (int k = 0; k < MAX_NODES; k++)
                deg_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        mode_reg    <= mode;
                        a_reg       <= node_label[LW-1:0];
                        b_reg       <= edge_to[LW-1:0];
                        idx_reg     <= '0;
                        ph_reg      <= 1'b0;
                        pos_reg     <= count_reg[IW-1:0];
                        dup_reg     <= 1'b0;
                        xf_reg      <= 1'b0;
                        yf_reg      <= 1'b0;
                        emitted_reg <= '0;
                        if (mode_t'(mode) == MODE_CLEAR)
                            count_reg <= '0;
                        if (mode_t'(mode) == MODE_RUN)
                            for (int k = 0; k < MAX_NODES; k++)
                                deg_reg[k] <= '0;
                    end
                ST_FIND:
                    if (idx_done)
                    begin
                        idx_reg <= (mode_t'(mode_reg) == MODE_EDGE) ? CW'(xi_reg) : count_reg;
                        ph_reg  <= 1'b0;
                    end
                    else if (!ph_reg)
                        ph_reg <= 1'b1;
                    else
                    begin
                        if (lab_q_reg == a_reg)
                        begin
                            dup_reg <= 1'b1;
                            xf_reg  <= 1'b1;
                            xi_reg  <= idx;
                        end
                        if (lab_q_reg == b_reg)
                        begin
                            yf_reg <= 1'b1;
                            yi_reg <= idx;
                        end
                        if (lab_q_reg > a_reg && pos_reg == count_reg[IW-1:0] && !dup_reg
                            && count_reg != CW'(MAX_NODES))
                            pos_reg <= idx;
                        idx_reg <= idx_reg + 1'b1;
                        ph_reg  <= 1'b0;
                    end
                ST_SET:
                    ph_reg <= !ph_reg;
                ST_SHIFT:
                    if (!shift_done)
                    begin
                        if (ph_reg)
                            idx_reg <= idx_reg - 1'b1;
                        ph_reg <= !ph_reg;
                    end
                ST_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                    idx_reg   <= '0;
                    ph_reg    <= 1'b0;
                end
                ST_COLS:
                    if (!idx_done)
                    begin
                        if (ph_reg)
                            idx_reg <= idx_reg + 1'b1;
                        ph_reg <= !ph_reg;
                    end
                ST_DEG:
                    if (!idx_done)
                    begin
                        if (ph_reg)
                        begin
                            for (int k = 0; k < MAX_NODES; k++)
                                if (row_q_reg[k] && CW'(k) < count_reg)
                                    deg_reg[k] <= deg_reg[k] + 1'b1;
                            idx_reg <= idx_reg + 1'b1;
                        end
                        ph_reg <= !ph_reg;
                    end
                    else
                        idx_reg <= '0;
                ST_SCAN:
                begin
                    level_reg <= ready_vec;
                    idx_reg   <= '0;
                    ph_reg    <= 1'b0;
                end
                ST_EMIT:
                    if (idx_done)
                        emitted_reg <= emitted_reg | level_reg;
                    else if (!level_reg[idx])
                        idx_reg <= idx_reg + 1'b1;
                    else if (!ph_reg)
                        ph_reg <= 1'b1;
                    else if (out_free)
                    begin
                        // word out and this row's out-edges removed together
                        o_label_reg <= 16'(lab_q_reg);
                        o_lend_reg  <= (rest == '0);
                        o_cyc_reg   <= 1'b0;
                        o_last_reg  <= (rest == '0) && final_level;
                        for (int k = 0; k < MAX_NODES; k++)
                            if (row_q_reg[k] && CW'(k) < count_reg && deg_reg[k] != '0)
                                deg_reg[k] <= deg_reg[k] - 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        ph_reg  <= 1'b0;
                    end
                ST_CYC:
                    if (out_free)
                    begin
                        o_label_reg <= '0;
                        o_lend_reg  <= 1'b0;
                        o_cyc_reg   <= 1'b1;
                        o_last_reg  <= 1'b1;
                    end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
